// ===== hdl/skyline_block_allocator_assert.svh =====
// Assertion macros for the skyline block allocator.
`ifndef SKYLINE_BLOCK_ALLOCATOR_ASSERT_SVH
`define SKYLINE_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define SBA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("skyline allocator check failed");

// Next-cycle implication, sampled on aclk, off while in reset.
`define SBA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("skyline allocator check failed");

`endif

// ===== hdl/sba_pkg.sv =====
`timescale 1ns / 1ps

package sba_pkg;

    localparam int ATLAS_WIDTH  = 128;
    localparam int ATLAS_HEIGHT = 128;

    localparam int COL_W = $clog2(ATLAS_WIDTH);       // column index
    localparam int HGT_W = $clog2(ATLAS_HEIGHT + 1);  // fill height 0..ATLAS_HEIGHT
    localparam int SIZE_W = 8;                        // block width/height fields
    localparam int POS_W  = 7;                        // result position fields
    localparam int OFF_W  = 14;                       // texel offset field

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_DECIDE = 5'b00100,
        ST_WRITE  = 5'b01000,
        ST_FINISH = 5'b10000
    } sba_state_t;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

endpackage

// ===== hdl/sba_ram.sv =====
`timescale 1ns / 1ps

module sba_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 128,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/skyline_block_allocator.sv =====
`timescale 1ns / 1ps
`include "skyline_block_allocator_assert.svh"

// Skyline block allocator: keeps one fill height per atlas column in a
// 128-entry RAM and places each requested block at the first start column
// whose tallest covered column is lowest. A clear request goes straight to
// the finish state; an allocate request scans the skyline, decides, and,
// when the block is placed, writes the new height into each covered column.
// The scan reads one column per cycle through the single read port of the
// height RAM, and on meeting a column that is already as high as the best
// height so far it jumps to the next column. For a block of width W the
// scan makes 127 reads on a flat skyline below the top, 128 - W on a full
// one, and at most (128 - W) * W. Widths of 0 or of 128 and more skip the
// scan. The block takes no new request while one is at work; a finished
// result waits in the output register and does not hold off the next request.
module skyline_block_allocator (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_kind,
    input  logic [sba_pkg::SIZE_W-1:0] s_block_width,
    input  logic [sba_pkg::SIZE_W-1:0] s_block_height,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_fits,
    output logic [sba_pkg::POS_W-1:0]  m_pos_s,
    output logic [sba_pkg::POS_W-1:0]  m_pos_t,
    output logic [sba_pkg::OFF_W-1:0]  m_texel_offset
);

    import sba_pkg::*;

    sba_state_t state_reg, state_next;

    logic [SIZE_W-1:0]      w_reg, w_next;
    logic [SIZE_W-1:0]      h_reg, h_next;
    logic [HGT_W-1:0]       best_reg, best_next;
    logic [COL_W-1:0]       best_s_reg, best_s_next;
    logic                   found_reg, found_next;
    logic [COL_W-1:0]       start_reg, start_next;
    logic [COL_W-1:0]       col_reg, col_next;
    logic [HGT_W-1:0]       span_reg, span_next;
    logic [SIZE_W-1:0]      cnt_reg, cnt_next;
    logic [HGT_W-1:0]       fill_reg, fill_next;
    logic                   res_fits_reg, res_fits_next;
    logic [POS_W-1:0]       res_s_reg, res_s_next;
    logic [POS_W-1:0]       res_t_reg, res_t_next;
    logic [ATLAS_WIDTH-1:0] valid_reg, valid_next;
    logic                   rd_vld_reg;

    logic                   m_valid_reg, m_valid_next;
    logic                   m_fits_reg;
    logic [POS_W-1:0]       m_pos_s_reg;
    logic [POS_W-1:0]       m_pos_t_reg;
    logic [OFF_W-1:0]       m_off_reg;
    logic                   out_load;

    logic [COL_W-1:0]       raddr;
    logic [HGT_W-1:0]       rdata;
    logic                   ram_we;

    logic [HGT_W-1:0]       col_h;
    logic                   hit;
    logic                   win_last;
    logic [HGT_W-1:0]       span_max;
    logic [COL_W+1:0]       q_inc;
    logic [COL_W+1:0]       i_inc;
    logic [COL_W+1:0]       new_start;
    logic                   scan_end;
    logic [COL_W+1:0]       top_sum;
    logic                   place_ok;
    logic                   in_xfer;

    assign s_ready = state_reg[0];
    assign in_xfer = s_valid && s_ready;
    assign out_load = state_reg == ST_FINISH && (!m_valid_reg || m_ready);

    sba_ram #(
        .DATA_W(HGT_W),
        .DEPTH (ATLAS_WIDTH)
    ) u_heights (
        .clk  (aclk),
        .we   (ram_we),
        .waddr(col_reg),
        .wdata(fill_reg),
        .raddr(raddr),
        .rdata(rdata)
    );

    // Scan datapath: compare the column read last cycle against the best so far.
    always_comb begin
        col_h     = rd_vld_reg ? rdata : '0;
        hit       = col_h >= best_reg;
        span_max  = (col_h > span_reg) ? col_h : span_reg;
        q_inc     = {2'b00, col_reg} + (COL_W+2)'(1);
        i_inc     = {2'b00, start_reg} + (COL_W+2)'(1);
        win_last  = ({2'b00, start_reg} + (COL_W+2)'(w_reg)) == q_inc;
        new_start = hit ? q_inc : i_inc;
        scan_end  = (hit || win_last) &&
                    (new_start + (COL_W+2)'(w_reg) > (COL_W+2)'(ATLAS_WIDTH - 1));
        top_sum   = (COL_W+2)'(best_reg) + (COL_W+2)'(h_reg);
        place_ok  = found_reg && top_sum <= (COL_W+2)'(ATLAS_HEIGHT);
    end

    always_comb begin
        state_next    = state_reg;
        w_next        = w_reg;
        h_next        = h_reg;
        best_next     = best_reg;
        best_s_next   = best_s_reg;
        found_next    = found_reg;
        start_next    = start_reg;
        col_next      = col_reg;
        span_next     = span_reg;
        cnt_next      = cnt_reg;
        fill_next     = fill_reg;
        res_fits_next = res_fits_reg;
        res_s_next    = res_s_reg;
        res_t_next    = res_t_reg;
        valid_next    = valid_reg;
        m_valid_next  = m_valid_reg;
        raddr         = '0;
        ram_we        = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    w_next     = s_block_width;
                    h_next     = s_block_height;
                    best_next  = HGT_W'(ATLAS_HEIGHT);
                    best_s_next = '0;
                    found_next = 1'b0;
                    start_next = '0;
                    col_next   = '0;
                    span_next  = '0;
                    if (s_kind == KIND_CLEAR) begin
                        valid_next    = '0;
                        res_fits_next = 1'b1;
                        res_s_next    = '0;
                        res_t_next    = '0;
                        state_next    = ST_FINISH;
                    end else if (s_block_width == '0) begin
                        // empty span sits at row 0 of column 0
                        best_next  = '0;
                        found_next = 1'b1;
                        state_next = ST_DECIDE;
                    end else if ((COL_W+2)'(s_block_width) >= (COL_W+2)'(ATLAS_WIDTH)) begin
                        state_next = ST_DECIDE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    // every window that covers this column is no better: skip past it
                    start_next = new_start[COL_W-1:0];
                    span_next  = '0;
                    raddr      = new_start[COL_W-1:0];
                end else if (win_last) begin
                    best_next   = span_max;
                    best_s_next = start_reg;
                    found_next  = 1'b1;
                    start_next  = new_start[COL_W-1:0];
                    span_next   = '0;
                    raddr       = new_start[COL_W-1:0];
                end else begin
                    span_next = span_max;
                    raddr     = q_inc[COL_W-1:0];
                end
                col_next = raddr;
                if (scan_end) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                fill_next     = top_sum[HGT_W-1:0];
                res_fits_next = place_ok;
                res_s_next    = place_ok ? POS_W'(best_s_reg) : '0;
                res_t_next    = place_ok ? best_reg[POS_W-1:0] : '0;
                col_next      = best_s_reg;
                cnt_next      = w_reg;
                state_next    = (place_ok && w_reg != '0) ? ST_WRITE : ST_FINISH;
            end
            ST_WRITE: begin
                ram_we              = 1'b1;
                valid_next[col_reg] = 1'b1;
                col_next            = col_reg + COL_W'(1);
                cnt_next            = cnt_reg - SIZE_W'(1);
                if (cnt_reg == SIZE_W'(1)) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
            rd_vld_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
            rd_vld_reg  <= valid_reg[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        w_reg        <= w_next;
        h_reg        <= h_next;
        best_reg     <= best_next;
        best_s_reg   <= best_s_next;
        found_reg    <= found_next;
        start_reg    <= start_next;
        col_reg      <= col_next;
        span_reg     <= span_next;
        cnt_reg      <= cnt_next;
        fill_reg     <= fill_next;
        res_fits_reg <= res_fits_next;
        res_s_reg    <= res_s_next;
        res_t_reg    <= res_t_next;
        if (out_load) begin
            m_fits_reg  <= res_fits_reg;
            m_pos_s_reg <= res_s_reg;
            m_pos_t_reg <= res_t_reg;
            m_off_reg   <= OFF_W'(int'(res_t_reg) * ATLAS_WIDTH + int'(res_s_reg));
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_fits         = m_fits_reg;
    assign m_pos_s        = m_pos_s_reg;
    assign m_pos_t        = m_pos_t_reg;
    assign m_texel_offset = m_off_reg;

    `SBA_ASSERT_NOW(a_full_is_zero, m_valid && !m_fits,
        m_pos_s == '0 && m_pos_t == '0 && m_texel_offset == '0)
    `SBA_ASSERT_NOW(a_scan_in_range, state_reg == ST_SCAN,
        ({2'b00, start_reg} + (COL_W+2)'(w_reg)) <= (COL_W+2)'(ATLAS_WIDTH - 1))
    `SBA_ASSERT_NOW(a_best_below_top, found_reg && state_reg == ST_DECIDE,
        best_reg < HGT_W'(ATLAS_HEIGHT))
    `SBA_ASSERT_NEXT(a_clear_empties, in_xfer && s_kind == KIND_CLEAR,
        valid_reg == '0 && state_reg == ST_FINISH)

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import sba_pkg::*;

    typedef struct {
        logic             fits;
        logic [POS_W-1:0] pos_s;
        logic [POS_W-1:0] pos_t;
        logic [OFF_W-1:0] texel_off;
    } placement_t;

    // Tracks the atlas skyline and the placements still owed by the block.
    class placement_checker;
        int unsigned skyline_fill [ATLAS_WIDTH];
        placement_t  pending_placements [$];
        int          errors;
        int          placed;
        int          refused;
        int          clears;

        function void take_request(logic kind, logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
            int unsigned best;
            int unsigned best_s;
            int unsigned span;
            int          start;
            int          k;
            bit          found;
            bit          ok;
            placement_t  p;
            best   = ATLAS_HEIGHT;
            best_s = 0;
            found  = 1'b0;
            p      = '{default: '0};
            if (kind == KIND_CLEAR) begin
                foreach (skyline_fill[i]) skyline_fill[i] = 0;
                p.fits = 1'b1;
                clears++;
            end else begin
                // Starts stop one short of the last possible column.
                if (w < ATLAS_WIDTH) begin
                    for (start = 0; start < ATLAS_WIDTH - w; start++) begin
                        span = 0;
                        ok   = 1'b1;
                        for (k = 0; k < w; k++) begin
                            if (skyline_fill[start + k] >= best) begin
                                ok = 1'b0;
                                break;
                            end
                            if (skyline_fill[start + k] > span) span = skyline_fill[start + k];
                        end
                        if (ok && span < best) begin
                            best   = span;
                            best_s = start;
                            found  = 1'b1;
                        end
                    end
                end
                if (found && best + h <= ATLAS_HEIGHT) begin
                    // Flatten the covered columns to the new top, even for zero height.
                    for (k = 0; k < w; k++) skyline_fill[best_s + k] = best + h;
                    p.fits      = 1'b1;
                    p.pos_s     = best_s[POS_W-1:0];
                    p.pos_t     = best[POS_W-1:0];
                    p.texel_off = OFF_W'(best * ATLAS_WIDTH + best_s);
                    placed++;
                end else begin
                    refused++;
                end
            end
            pending_placements.push_back(p);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_placement(logic fits, logic [POS_W-1:0] pos_s,
                                      logic [POS_W-1:0] pos_t, logic [OFF_W-1:0] texel_off);
            placement_t want;
            if (pending_placements.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected result, expected none, %s%0b s=%0d t=%0d off=%0d",
                         $time, "actual fits=", fits, pos_s, pos_t, texel_off);
                return;
            end
            want = pending_placements.pop_front();
            compare_field("fits", want.fits, fits);
            compare_field("pos_s", want.pos_s, pos_s);
            compare_field("pos_t", want.pos_t, pos_t);
            compare_field("texel_offset", want.texel_off, texel_off);
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic              s_kind;
    logic [SIZE_W-1:0] s_block_width;
    logic [SIZE_W-1:0] s_block_height;
    logic              m_valid;
    logic              m_ready;
    logic              m_fits;
    logic [POS_W-1:0]  m_pos_s;
    logic [POS_W-1:0]  m_pos_t;
    logic [OFF_W-1:0]  m_texel_offset;

    placement_checker board = new;

    int tx_idle_pct;
    int rx_idle_pct;
    int rx_hold_req;
    int rx_hold_left;

    skyline_block_allocator u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_block_width  (s_block_width),
        .s_block_height (s_block_height),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_fits         (m_fits),
        .m_pos_s        (m_pos_s),
        .m_pos_t        (m_pos_t),
        .m_texel_offset (m_texel_offset)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            board.take_request(s_kind, s_block_width, s_block_height);
        if (aresetn && m_valid && m_ready)
            board.check_placement(m_fits, m_pos_s, m_pos_t, m_texel_offset);
    end

    // Result side: random back-pressure, or a long hold when one is requested.
    initial begin
        m_ready      = 1'b0;
        rx_hold_left = 0;
        forever begin
            @(negedge aclk);
            if (rx_hold_req > 0) begin
                rx_hold_left = rx_hold_req;
                rx_hold_req  = 0;
            end
            if (rx_hold_left > 0) begin
                m_ready <= 1'b0;
                rx_hold_left--;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    task automatic send_request(logic kind, logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
        @(negedge aclk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_kind         <= kind;
        s_block_width  <= w;
        s_block_height <= h;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_placements;
        @(negedge aclk);
        s_valid <= 1'b0;
        while (board.pending_placements.size() != 0) @(negedge aclk);
    endtask

    // Mostly packing runs of ordinary blocks, with rare clears and some odd sizes.
    task automatic send_random_request;
        int                r;
        logic [SIZE_W-1:0] w;
        logic [SIZE_W-1:0] h;
        r = $urandom_range(0, 999);
        w = ($urandom_range(0, 9) == 0) ? SIZE_W'($urandom_range(1, 128))
                                        : SIZE_W'($urandom_range(1, 24));
        h = ($urandom_range(0, 9) == 0) ? SIZE_W'($urandom_range(1, 128))
                                        : SIZE_W'($urandom_range(1, 24));
        if (r < 15) begin
            send_request(KIND_CLEAR, SIZE_W'($urandom), SIZE_W'($urandom));
        end else if (r < 95) begin
            case ($urandom_range(0, 4))
                0:       w = '0;
                1:       w = SIZE_W'($urandom_range(128, 255));
                2:       h = '0;
                3:       h = SIZE_W'($urandom_range(129, 255));
                default: begin
                    w = SIZE_W'($urandom);
                    h = SIZE_W'($urandom);
                end
            endcase
            send_request(KIND_ALLOC, w, h);
        end else begin
            send_request(KIND_ALLOC, w, h);
        end
        if ($urandom_range(0, 99) == 0) drain_placements();
    endtask

    task automatic run_phase(int tx_pct, int rx_pct, int count);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (count) send_random_request();
        drain_placements();
    endtask

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_kind         = KIND_ALLOC;
        s_block_width  = '0;
        s_block_height = '0;
        tx_idle_pct    = 16;
        rx_idle_pct    = 71;
        rx_hold_req    = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_request(KIND_ALLOC, 8'd4, 8'd10);
        send_request(KIND_ALLOC, 8'd4, 8'd3);
        send_request(KIND_ALLOC, 8'd0, 8'd5);
        send_request(KIND_ALLOC, 8'd8, 8'd0);
        send_request(KIND_ALLOC, 8'd127, 8'd1);
        send_request(KIND_ALLOC, 8'd1, 8'd129);
        send_request(KIND_CLEAR, 8'd0, 8'd0);
        // Fill every reachable start to the top, leaving only the last column.
        send_request(KIND_ALLOC, 8'd127, 8'd128);
        send_request(KIND_ALLOC, 8'd1, 8'd1);
        send_request(KIND_ALLOC, 8'd0, 8'd0);
        send_request(KIND_ALLOC, 8'd0, 8'd129);
        send_request(KIND_CLEAR, 8'd255, 8'd255);
        send_request(KIND_ALLOC, 8'd128, 8'd1);
        send_request(KIND_ALLOC, 8'd255, 8'd255);
        send_request(KIND_ALLOC, 8'd1, 8'd128);
        send_request(KIND_ALLOC, 8'd1, 8'd128);
        send_request(KIND_ALLOC, 8'd64, 8'd127);
        send_request(KIND_ALLOC, 8'd126, 8'd1);
        send_request(KIND_ALLOC, 8'd5, 8'd1);
        send_request(KIND_ALLOC, 8'd1, 8'd127);
        send_request(KIND_CLEAR, 8'd170, 8'd85);
        drain_placements();

        run_phase(16, 71, 176);
        run_phase(71, 16, 176);
        // Hold results off long enough for the block to stall its input.
        rx_hold_req = 600;
        run_phase(0, 0, 176);

        repeat (50) @(negedge aclk);
        $display("Checked %0d placements, %0d full refusals and %0d clears.",
                 board.placed, board.refused, board.clears);
        $display("Traffic ran with sender and receiver idling in turn, then back to back.");
        if (board.errors == 0 && board.pending_placements.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #250_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
